FILE: design/romaji_word_token_scanner_core_defines.svh
// Assertion macros shared by the romaji word token scanner RTL.
`ifndef ROMAJI_WORD_TOKEN_SCANNER_CORE_DEFINES_SVH
`define ROMAJI_WORD_TOKEN_SCANNER_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define RWTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define RWTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rwts_pkg.sv
// Types, constants and lexicon table of the romaji word token scanner.
`default_nettype none
package rwts_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int RES_COUNT   = 19;
	localparam int RES_MAX_LEN = 12;
	localparam int EOFM_SLOT   = 18;

	// Character class produced by the front end
	typedef enum logic [3:0] {
		CC_VOWEL,
		CC_N,
		CC_S,
		CC_T,
		CC_C,
		CC_H,
		CC_Y,
		CC_C5,
		CC_C6,
		CC_OTHER
	} char_class_t;

	// Syllable automaton states
	typedef enum logic [3:0] {
		ST_START,
		ST_VOWEL,
		ST_VOWEL_N,
		ST_C,
		ST_T,
		ST_CONS,
		ST_NEED_VOWEL,
		ST_S,
		ST_DEAD
	} dfa_state_t;

	// Token codes
	typedef enum logic [3:0] {
		TOK_WORD1,
		TOK_WORD2,
		TOK_PERIOD,
		TOK_VERB,
		TOK_VERBNEG,
		TOK_VERBPAST,
		TOK_VERBPASTNEG,
		TOK_IS,
		TOK_WAS,
		TOK_OBJECT,
		TOK_SUBJECT,
		TOK_DESTINATION,
		TOK_PRONOUN,
		TOK_CONNECTOR,
		TOK_ERROR,
		TOK_EOFM
	} token_t;

	// One character as it travels from front to back
	typedef struct packed {
		logic [7:0]  ch;
		logic        last_char;
		char_class_t cls;
	} item_t;

	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_UPPER_I = 8'h49;
	localparam logic [7:0] CH_UPPER_E = 8'h45;

	// Reserved words, right justified (first character in the highest used byte)
	localparam logic [RES_MAX_LEN*8-1:0] RES_TEXT [RES_COUNT] = '{
		"masu", "masen", "mashita", "masendeshita", "desu", "deshita",
		"o", "wa", "ni", "watashi", "anata", "kare", "kanojo", "sore",
		"mata", "soshite", "shikashi", "dakara", "eofm"
	};

	localparam logic [3:0] RES_LEN [RES_COUNT] = '{
		4'd4, 4'd5, 4'd7, 4'd12, 4'd4, 4'd7, 4'd1, 4'd2, 4'd2, 4'd7,
		4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd7, 4'd8, 4'd6, 4'd4
	};

	localparam token_t RES_CODE [RES_COUNT] = '{
		TOK_VERB, TOK_VERBNEG, TOK_VERBPAST, TOK_VERBPASTNEG, TOK_IS, TOK_WAS,
		TOK_OBJECT, TOK_SUBJECT, TOK_DESTINATION, TOK_PRONOUN, TOK_PRONOUN,
		TOK_PRONOUN, TOK_PRONOUN, TOK_PRONOUN, TOK_CONNECTOR, TOK_CONNECTOR,
		TOK_CONNECTOR, TOK_CONNECTOR, TOK_EOFM
	};

	// True when character c at position idx agrees with reserved word r
	function automatic logic res_match(input int r, input logic [3:0] idx,
			input logic [7:0] c);
		logic [6:0] ofs;
		logic       hit;
		ofs = 7'd0;
		hit = 1'b0;
		if (idx < RES_LEN[r]) begin
			ofs = {3'd0, 4'(RES_LEN[r] - 4'd1 - idx)} << 3;
			hit = (RES_TEXT[r][ofs +: 8] == c);
		end
		return hit;
	endfunction

endpackage
`default_nettype wire

FILE: design/rwts_front.sv
// Front end: accepts characters and classifies them for the automaton.
`default_nettype none
`include "romaji_word_token_scanner_core_defines.svh"
module rwts_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_ch,
	input  wire logic          in_last,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rwts_pkg::item_t    out_item
);
	import rwts_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	char_class_t cls;

	// Classify the incoming character
	always_comb begin
		case (in_ch) inside
			"a", "e", "i", "o", "u", "I", "E": cls = CC_VOWEL;
			"n":                               cls = CC_N;
			"s":                               cls = CC_S;
			"t":                               cls = CC_T;
			"c":                               cls = CC_C;
			"h":                               cls = CC_H;
			"y":                               cls = CC_Y;
			"b", "g", "k", "m", "p", "r":      cls = CC_C5;
			"d", "j", "w", "z":                cls = CC_C6;
			default:                           cls = CC_OTHER;
		endcase
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	// Hold the stage until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.ch        <= in_ch;
			item_s1.last_char <= in_last;
			item_s1.cls       <= cls;
		end
	end

	`RWTS_ASSERT_NEXT(a_front_hold, clk, arst_n, valid_s1 && !out_ready, valid_s1,
		"front stage dropped a stalled character")

endmodule
`default_nettype wire

FILE: design/rwts_queue.sv
// Short queue between front end and back end.
`default_nettype none
`include "romaji_word_token_scanner_core_defines.svh"
module rwts_queue #(
	parameter int DEPTH = rwts_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire rwts_pkg::item_t push_item,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output rwts_pkg::item_t    pop_item
);
	import rwts_pkg::*;

	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);

	item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != COUNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`RWTS_ASSERT_SAME(a_queue_bound, clk, arst_n, 1'b1, count_q <= COUNT_W'(DEPTH),
		"queue occupancy above depth")
	`RWTS_ASSERT_NEXT(a_queue_count, clk, arst_n, push && !pop,
		count_q == $past(count_q) + 1'b1, "queue count missed a push")

endmodule
`default_nettype wire

FILE: design/rwts_back.sv
// Back end: syllable automaton, reserved-word match and token decision.
`default_nettype none
`include "romaji_word_token_scanner_core_defines.svh"
module rwts_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire rwts_pkg::item_t in_item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output rwts_pkg::token_t     out_token
);
	import rwts_pkg::*;

	dfa_state_t           state_q;
	logic [RES_COUNT-1:0] hits_q;
	logic [3:0]           idx_q;
	logic                 dot_q;
	logic                 out_valid_q;
	token_t               token_q;

	dfa_state_t           state_d;
	logic [RES_COUNT-1:0] ok;
	logic [RES_COUNT-1:0] full;
	logic                 dot_d;
	token_t               token_d;
	logic                 take;

	// Drain non-final characters freely; a final one needs room in the output
	assign in_ready  = !in_item.last_char || !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_token = token_q;

	// Automaton next state
	always_comb begin
		state_d = ST_DEAD;
		case (state_q)
			ST_START, ST_VOWEL, ST_VOWEL_N: begin
				case (in_item.cls)
					CC_VOWEL:           state_d = ST_VOWEL;
					CC_N:               state_d = (state_q == ST_VOWEL) ? ST_VOWEL_N : ST_CONS;
					CC_C5, CC_H:        state_d = ST_CONS;
					CC_C6, CC_Y:        state_d = ST_NEED_VOWEL;
					CC_T:               state_d = ST_T;
					CC_C:               state_d = ST_C;
					CC_S:               state_d = ST_S;
					default:            state_d = ST_DEAD;
				endcase
			end
			ST_C: state_d = (in_item.cls == CC_H) ? ST_NEED_VOWEL : ST_DEAD;
			ST_T: begin
				if (in_item.cls == CC_S) state_d = ST_NEED_VOWEL;
				else if (in_item.cls == CC_VOWEL) state_d = ST_VOWEL;
			end
			ST_CONS: begin
				if (in_item.cls == CC_Y) state_d = ST_NEED_VOWEL;
				else if (in_item.cls == CC_VOWEL) state_d = ST_VOWEL;
			end
			ST_NEED_VOWEL: state_d = (in_item.cls == CC_VOWEL) ? ST_VOWEL : ST_DEAD;
			ST_S: begin
				if (in_item.cls == CC_H) state_d = ST_NEED_VOWEL;
				else if (in_item.cls == CC_VOWEL) state_d = ST_VOWEL;
			end
			default: state_d = ST_DEAD;
		endcase
	end

	// Compare against every reserved word at once
	always_comb begin
		for (int r = 0; r < RES_COUNT; r++) begin
			ok[r]   = res_match(r, idx_q, in_item.ch);
			full[r] = ok[r] && hits_q[r] && ({1'b0, idx_q} + 5'd1 == {1'b0, RES_LEN[r]});
		end
	end

	assign dot_d = dot_q && (idx_q == 4'd0) && (in_item.ch == CH_DOT);

	// Pick the token for a final character
	always_comb begin
		token_d = TOK_ERROR;
		if (full[EOFM_SLOT]) begin
			token_d = TOK_EOFM;
		end else if (state_d == ST_START || state_d == ST_VOWEL || state_d == ST_VOWEL_N) begin
			token_d = (in_item.ch == CH_UPPER_I || in_item.ch == CH_UPPER_E) ?
				TOK_WORD2 : TOK_WORD1;
			for (int r = 0; r < RES_COUNT; r++) begin
				if (full[r]) token_d = RES_CODE[r];
			end
		end else if (dot_d) begin
			token_d = TOK_PERIOD;
		end
	end

	// Advance per-word state; clear it after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			hits_q      <= '1;
			idx_q       <= '0;
			dot_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (take && in_item.last_char) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (in_item.last_char) begin
					state_q <= ST_START;
					hits_q  <= '1;
					idx_q   <= '0;
					dot_q   <= 1'b1;
				end else begin
					state_q <= state_d;
					hits_q  <= hits_q & ok;
					dot_q   <= dot_d;
					if (idx_q != 4'd15) begin
						idx_q <= idx_q + 4'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_item.last_char) begin
			token_q <= token_d;
		end
	end

	`RWTS_ASSERT_NEXT(a_back_word_clear, clk, arst_n, take && in_item.last_char,
		state_q == ST_START && hits_q == '1 && idx_q == 4'd0 && dot_q && out_valid_q,
		"per-word state not cleared after final character")

endmodule
`default_nettype wire

FILE: design/romaji_word_token_scanner_core.sv
// Top level of the romaji word token scanner.
// Takes one word character per transaction on the s_axis side, tlast on the
// final character, and gives one token code on the m_axis side per word.
// Sustains one character per clock unless a final character is held behind a
// waiting token. A token is presented on m_axis after its final character is
// accepted and passes the front register, then the queue, then the output
// register, loaded as the back end takes the character. Throughput is set by
// the back end, which updates the syllable automaton and all 19 reserved-word
// comparators for one character a cycle. While a token waits on m_axis_tready
// the back end keeps taking ordinary characters and holds only the next final
// character; the queue and the front register then fill before s_axis_tready
// drops. No clearing pass follows reset.
`default_nettype none
module romaji_word_token_scanner_core #(
	parameter int QUEUE_DEPTH = rwts_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
	input  wire logic       s_axis_tlast,   // last_char
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata    // [3:0] token_type, [7:4] zero
);
	import rwts_pkg::*;

	logic   fq_valid;
	logic   fq_ready;
	item_t  fq_item;
	logic   qb_valid;
	logic   qb_ready;
	item_t  qb_item;
	token_t token;

	rwts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_ch     (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_item  (fq_item)
	);

	rwts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	rwts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (qb_valid),
		.in_ready  (qb_ready),
		.in_item   (qb_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_token (token)
	);

	assign m_axis_tdata = {4'd0, token};

endmodule
`default_nettype wire

FILE: tb/sv/romaji_word_token_scanner_core_tb.sv
// Self-checking testbench of the romaji word token scanner: streams words, predicts tokens.
`default_nettype none
module romaji_word_token_scanner_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rwts_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_CHARS = 980;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;

	// Lexicon of reserved words and the token each one yields
	string  lex_word [RES_COUNT] = '{
		"masu", "masen", "mashita", "masendeshita", "desu", "deshita",
		"o", "wa", "ni", "watashi", "anata", "kare", "kanojo", "sore",
		"mata", "soshite", "shikashi", "dakara", "eofm"
	};
	token_t lex_class [RES_COUNT] = '{
		TOK_VERB, TOK_VERBNEG, TOK_VERBPAST, TOK_VERBPASTNEG, TOK_IS, TOK_WAS,
		TOK_OBJECT, TOK_SUBJECT, TOK_DESTINATION, TOK_PRONOUN, TOK_PRONOUN,
		TOK_PRONOUN, TOK_PRONOUN, TOK_PRONOUN, TOK_CONNECTOR, TOK_CONNECTOR,
		TOK_CONNECTOR, TOK_CONNECTOR, TOK_EOFM
	};

	string directed_words [23] = '{
		"masu", "masen", "mashita", "masendeshita", "desu", "deshita", "o",
		"wa", "ni", "watashi", "soshite", "eofm", ".", "..", "kaI", "sE",
		"konnichiwa", "tsuchi", "shikashi", "an", "n", "kyaxb",
		"watashiwanihonjindesu"
	};

	string vowel_set  = "aeiouIE";
	string single_set = "bdghjkmnprstwyz";
	string pair_set   = "bygyhykymynypyrychshts";
	string noise_set  = "aeiouIEbcdghjkmnprstwyz.";

	// Scanner state as predicted
	dfa_state_t           syl_state = ST_START;
	logic [RES_COUNT-1:0] lex_live  = '1;
	logic [3:0]           char_pos  = 4'd0;
	logic                 lone_dot  = 1'b1;

	char_item_t pending_chars [$];
	token_t     expected_tokens [$];

	char_item_t next_char;
	token_t     want_tok;
	int         total_chars = 0;
	int         n_accepted  = 0;
	int         fail_count  = 0;
	int         tx_wait     = 0;
	int         tx_calm     = 0;
	int         rx_wait     = 0;
	int         rx_calm     = 0;
	int         rx_gap;
	int         stall_left  = 0;
	logic       stall_done  = 1'b0;
	int         cycle_count = 0;

	romaji_word_token_scanner_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic is_vowel(input logic [7:0] c);
		return c == "a" || c == "e" || c == "i" || c == "o" || c == "u" ||
			c == "I" || c == "E";
	endfunction

	// Transition from a state where a new syllable may begin
	function automatic dfa_state_t syl_from_start(input logic [7:0] c, input logic after_vowel);
		if (is_vowel(c))
			return ST_VOWEL;
		if (after_vowel && c == "n")
			return ST_VOWEL_N;
		case (c)
			"d", "j", "w", "y", "z": return ST_NEED_VOWEL;
			"b", "g", "h", "k", "m", "n", "p", "r": return ST_CONS;
			"t": return ST_T;
			"c": return ST_C;
			"s": return ST_S;
			default: return ST_DEAD;
		endcase
	endfunction

	function automatic dfa_state_t syl_next(input dfa_state_t st, input logic [7:0] c);
		case (st)
			ST_START, ST_VOWEL_N: return syl_from_start(c, 1'b0);
			ST_VOWEL: return syl_from_start(c, 1'b1);
			ST_C: return (c == "h") ? ST_NEED_VOWEL : ST_DEAD;
			ST_T: return (c == "s") ? ST_NEED_VOWEL : (is_vowel(c) ? ST_VOWEL : ST_DEAD);
			ST_CONS: return (c == "y") ? ST_NEED_VOWEL : (is_vowel(c) ? ST_VOWEL : ST_DEAD);
			ST_NEED_VOWEL: return is_vowel(c) ? ST_VOWEL : ST_DEAD;
			ST_S: return (c == "h") ? ST_NEED_VOWEL : (is_vowel(c) ? ST_VOWEL : ST_DEAD);
			default: return ST_DEAD;
		endcase
	endfunction

	// Advance the scanner by one accepted character; queue a token on the last one
	function automatic void scan_char(input logic [7:0] c, input logic last);
		logic [RES_COUNT-1:0] full;
		logic                 ok;
		token_t               tok;
		full = '0;
		syl_state = syl_next(syl_state, c);
		for (int r = 0; r < RES_COUNT; r++) begin
			ok = (char_pos < lex_word[r].len()) && (lex_word[r][char_pos] == c);
			if (!ok)
				lex_live[r] = 1'b0;
			else if (last && char_pos + 1 == lex_word[r].len() && lex_live[r])
				full[r] = 1'b1;
		end
		if (!(char_pos == 4'd0 && c == CH_DOT))
			lone_dot = 1'b0;
		if (!last) begin
			if (char_pos != 4'd15)
				char_pos = char_pos + 4'd1;
		end else begin
			if (full[EOFM_SLOT]) begin
				tok = TOK_EOFM;
			end else if (syl_state <= ST_VOWEL_N) begin
				tok = (c == CH_UPPER_I || c == CH_UPPER_E) ? TOK_WORD2 : TOK_WORD1;
				for (int r = 0; r < RES_COUNT; r++)
					if (full[r])
						tok = lex_class[r];
			end else if (lone_dot) begin
				tok = TOK_PERIOD;
			end else begin
				tok = TOK_ERROR;
			end
			expected_tokens.push_back(tok);
			syl_state = ST_START;
			lex_live  = '1;
			char_pos  = 4'd0;
			lone_dot  = 1'b1;
		end
	endfunction

	// Draw an idle gap, with calm stretches of no idling in between
	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left = calm_left - 1;
			return 0;
		end
		if ($urandom_range(0, 9) == 0)
			calm_left = $urandom_range(20, 80);
		return $urandom_range(0, 19);
	endfunction

	function automatic string one_char(input logic [7:0] c);
		string s;
		s = " ";
		s[0] = c;
		return s;
	endfunction

	// Build a well-formed word of count syllables
	function automatic string make_syllables(input int count);
		string w;
		int    p;
		w = "";
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 2))
				0: ;
				1: w = {w, one_char(single_set[$urandom_range(0, single_set.len() - 1)])};
				default: begin
					p = $urandom_range(0, pair_set.len() / 2 - 1);
					w = {w, pair_set.substr(2 * p, 2 * p + 1)};
				end
			endcase
			w = {w, one_char(vowel_set[$urandom_range(0, vowel_set.len() - 1)])};
			if ($urandom_range(0, 3) == 0)
				w = {w, "n"};
		end
		return w;
	endfunction

	task automatic push_char(input logic [7:0] c, input logic last);
		char_item_t it;
		it.ch   = c;
		it.last = last;
		pending_chars.push_back(it);
	endtask

	task automatic push_word(input string w);
		for (int i = 0; i < w.len(); i++)
			push_char(w[i], i == w.len() - 1);
	endtask

	task automatic note_fail(input string what, input logic [7:0] want, input logic [7:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("%s: expected 0x%02h, got 0x%02h", what, want, got);
	endtask

	// Fill the character queue, release reset, wait for the drain
	initial begin : stimulus
		string w;
		int    k;
		int    n;
		foreach (directed_words[i])
			push_word(directed_words[i]);
		push_char(8'h00, 1'b1);
		push_char(8'h80, 1'b1);
		push_char(8'hFF, 1'b1);
		n = pending_chars.size();
		while (pending_chars.size() - n < RANDOM_CHARS) begin
			k = $urandom_range(0, 99);
			if (k < 25) begin
				w = lex_word[$urandom_range(0, RES_COUNT - 1)];
				case ($urandom_range(0, 5))
					0: w = w.substr(0, $urandom_range(1, w.len()) - 1);
					1: w = {w, make_syllables(1)};
					2: w[$urandom_range(0, w.len() - 1)] =
						noise_set[$urandom_range(0, noise_set.len() - 1)];
					default: ;
				endcase
				push_word(w);
			end else if (k < 65) begin
				if ($urandom_range(0, 19) == 0)
					push_word(make_syllables($urandom_range(8, 10)));
				else
					push_word(make_syllables($urandom_range(1, 4)));
			end else if (k < 75) begin
				k = $urandom_range(1, 6);
				for (int i = 0; i < k; i++)
					push_char(8'($urandom_range(0, 255)), i == k - 1);
			end else if (k < 80) begin
				push_word(".");
			end else begin
				w = "";
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++)
					w = {w, one_char(noise_set[$urandom_range(0, noise_set.len() - 1)])};
				push_word(w);
			end
		end
		total_chars = pending_chars.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted != total_chars)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_tokens.size() == 0)
			$display("romaji_word_token_scanner_core: match");
		else
			$display("romaji_word_token_scanner_core: mismatch");
		$finish;
	end

	// Drive characters from the queue, idling between transactions
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				scan_char(s_axis_tdata, s_axis_tlast);
				n_accepted <= n_accepted + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_wait != 0) begin
					tx_wait <= tx_wait - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_chars.size() != 0) begin
					next_char = pending_chars.pop_front();
					s_axis_tdata  <= next_char.ch;
					s_axis_tlast  <= next_char.last;
					s_axis_tvalid <= 1'b1;
					tx_wait <= draw_gap(tx_calm);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check each token transaction against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (expected_tokens.size() == 0) begin
				note_fail("token with none pending", 8'h00, m_axis_tdata);
			end else begin
				want_tok = expected_tokens.pop_front();
				if (m_axis_tdata != {4'd0, want_tok})
					note_fail("token mismatch", {4'd0, want_tok}, m_axis_tdata);
			end
			rx_gap = draw_gap(rx_calm);
			rx_wait <= rx_gap;
			m_axis_tready <= (rx_gap == 0) && (stall_left == 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (stall_left == 0);
		end
	end

	// Hold off the receiver once for a long stretch so the block backs up
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!stall_done && n_accepted >= 300) begin
			stall_left <= 600;
			stall_done <= 1'b1;
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("romaji_word_token_scanner_core: mismatch");
			$finish;
		end
	end

endmodule
`default_nettype wire

FILE: files.f
+incdir+design
design/rwts_pkg.sv
design/rwts_front.sv
design/rwts_queue.sv
design/rwts_back.sv
design/romaji_word_token_scanner_core.sv
tb/sv/romaji_word_token_scanner_core_tb.sv
